// ===== sv/note_event_gate_tracker_top_defines.svh =====
// Assertion macros for the note event gate tracker
`ifndef NOTE_EVENT_GATE_TRACKER_TOP_DEFINES_SVH
`define NOTE_EVENT_GATE_TRACKER_TOP_DEFINES_SVH
`define NEGT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define NEGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/negt_pkg.sv =====
package negt_pkg;
  localparam int NOTES = 128;
  localparam int NOTE_BITS = 7;
  localparam int SCAN = 64;
  localparam int SCAN_BITS = 6;
  localparam int TIME_BITS = 32;
  localparam logic [10:0] FULL_SCALE = 11'd1024;

  localparam logic [1:0] REG_SILENCE = 2'd0;
  localparam logic [1:0] REG_CAPTURE = 2'd1;
  localparam logic [1:0] REG_HOLD = 2'd2;
  localparam logic [1:0] REG_LEVEL = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVRD,
    ST_EVWR,
    ST_SCRD,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] first_start;
    logic [15:0] last_end;
    logic [10:0] peak_amp;
  } win_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] last_seen;
  } trk_t;
endpackage

// ===== sv/note_event_gate_tracker_top.sv =====
// Note event gate tracker. An event (cmd 0) is one read-modify-write of the window
// memory. A close (cmd 1) has one read state, a scan of 64 notes (one note per cycle,
// one read of the window and tracking memories each) and one flush state. Closing
// bank 1 then runs the clearing pass of the window memory. The same pass runs after
// reset. busy is high throughout. Results appear on out_valid for one cycle each and
// cannot be stalled; out_last marks the final message of a close. Events that start
// before the silence length or end at or before it are ignored.
`include "note_event_gate_tracker_top_defines.svh"
module note_event_gate_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [6:0]  in_pitch,
  input  logic [15:0] in_start_sample,
  input  logic [15:0] in_end_sample,
  input  logic [10:0] in_amplitude,
  input  logic        in_bank,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  output logic        out_is_off,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [15:0] out_offset,
  output logic        out_last
);
  localparam int TB = negt_pkg::TIME_BITS;

  negt_pkg::state_t state_r, state_nxt;
  logic [15:0] silence_r, capture_r, hold_r;
  logic [10:0] level_r;
  logic [TB-1:0] base_r, base_nxt;
  logic [negt_pkg::NOTES-1:0] held_r, seen_r;
  logic [negt_pkg::NOTE_BITS-1:0] cnt_r, cnt_nxt;
  logic [negt_pkg::SCAN_BITS:0] scan_r, scan_nxt;
  logic bank_r;
  logic [6:0] pitch_r;
  logic [15:0] adj_s_r, adj_e_r;
  logic [10:0] amp_r;
  logic ev_ok_r;

  negt_pkg::win_t win_mem [negt_pkg::NOTES];
  negt_pkg::trk_t trk_mem [negt_pkg::NOTES];
  negt_pkg::win_t win_rd_r;
  negt_pkg::trk_t trk_rd_r;
  logic [6:0] rd_addr, wr_addr, scan_note_r;
  logic win_we, trk_we;
  negt_pkg::win_t win_wd;
  negt_pkg::trk_t trk_wd;

  logic pend_r;
  logic pend_off_r;
  logic [6:0] pend_note_r, pend_vel_r;
  logic [15:0] pend_off_val_r;
  logic emit;
  logic emit_off;
  logic [6:0] emit_vel;
  logic [15:0] emit_offset;

  logic out_valid_r, out_is_off_r, out_last_r;
  logic [6:0] out_note_r, out_vel_r;
  logic [15:0] out_offset_r;

  logic [10:0] a_c, lv_c, v_c;
  logic [17:0] vel_prod;
  logic [TB-1:0] win_end, elapsed, excess;
  logic scan_active;
  logic [15:0] ev_s, ev_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r <= '0;
      capture_r <= 16'd44100;
      hold_r <= '0;
      level_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        negt_pkg::REG_SILENCE: silence_r <= cfg_data;
        negt_pkg::REG_CAPTURE: capture_r <= cfg_data;
        negt_pkg::REG_HOLD: hold_r <= cfg_data;
        negt_pkg::REG_LEVEL: level_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign busy = (state_r != negt_pkg::ST_IDLE);
  assign scan_active = (state_r == negt_pkg::ST_SCAN);

  always_comb begin
    ev_s = in_start_sample - silence_r;
    ev_e = in_end_sample - silence_r;
    if (ev_e > capture_r) begin
      ev_e = capture_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      pitch_r <= in_pitch;
      adj_s_r <= ev_s;
      adj_e_r <= ev_e;
      amp_r <= in_amplitude;
      bank_r <= in_bank;
      ev_ok_r <= (in_start_sample >= silence_r) && (in_end_sample > silence_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    scan_nxt = scan_r;
    base_nxt = base_r;
    rd_addr = pitch_r;
    unique case (state_r)
      negt_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(negt_pkg::NOTES - 1)) begin
          state_nxt = negt_pkg::ST_IDLE;
        end
      end
      negt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = in_cmd ? negt_pkg::ST_SCRD : negt_pkg::ST_EVRD;
          scan_nxt = '0;
        end
      end
      negt_pkg::ST_EVRD: state_nxt = negt_pkg::ST_EVWR;
      negt_pkg::ST_EVWR: state_nxt = negt_pkg::ST_IDLE;
      negt_pkg::ST_SCRD: begin
        rd_addr = {bank_r, scan_r[5:0]};
        scan_nxt = scan_r + 7'd1;
        state_nxt = negt_pkg::ST_SCAN;
      end
      negt_pkg::ST_SCAN: begin
        rd_addr = {bank_r, scan_r[5:0]};
        scan_nxt = scan_r + 7'd1;
        if (scan_r == 7'(negt_pkg::SCAN)) begin
          state_nxt = negt_pkg::ST_DONE;
        end
      end
      negt_pkg::ST_DONE: begin
        if (bank_r) begin
          base_nxt = base_r + TB'(capture_r);
          state_nxt = negt_pkg::ST_CLEAR;
          cnt_nxt = '0;
        end else begin
          state_nxt = negt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = negt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= negt_pkg::ST_CLEAR;
      cnt_r <= '0;
      scan_r <= '0;
      base_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      scan_r <= scan_nxt;
      base_r <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_note_r <= rd_addr;
    win_rd_r <= win_mem[rd_addr];
    trk_rd_r <= trk_mem[rd_addr];
    if (win_we) begin
      win_mem[wr_addr] <= win_wd;
    end
    if (trk_we) begin
      trk_mem[wr_addr] <= trk_wd;
    end
  end

  always_comb begin
    a_c = (win_rd_r.peak_amp > negt_pkg::FULL_SCALE) ? negt_pkg::FULL_SCALE
                                                   : win_rd_r.peak_amp;
    lv_c = (level_r > negt_pkg::FULL_SCALE) ? negt_pkg::FULL_SCALE : level_r;
    v_c = (a_c > lv_c) ? a_c : lv_c;
    vel_prod = 18'(v_c) * 18'd127;
    win_end = base_r + TB'(capture_r);
    elapsed = win_end - trk_rd_r.last_seen;
    excess = elapsed - TB'(hold_r);
    emit = 1'b0;
    emit_off = 1'b0;
    emit_vel = '0;
    emit_offset = '0;
    win_we = 1'b0;
    trk_we = 1'b0;
    wr_addr = scan_note_r;
    win_wd = win_rd_r;
    trk_wd.last_seen = base_r + TB'(win_rd_r.last_end);
    unique case (state_r)
      negt_pkg::ST_CLEAR: begin
        win_we = 1'b1;
        wr_addr = cnt_r;
        win_wd.first_start = capture_r;
        win_wd.last_end = '0;
        win_wd.peak_amp = '0;
      end
      negt_pkg::ST_EVWR: begin
        win_we = ev_ok_r;
        wr_addr = pitch_r;
        if (adj_s_r < win_rd_r.first_start) win_wd.first_start = adj_s_r;
        if (adj_e_r > win_rd_r.last_end) win_wd.last_end = adj_e_r;
        if (amp_r > win_rd_r.peak_amp) win_wd.peak_amp = amp_r;
      end
      negt_pkg::ST_SCAN: begin
        if (seen_r[scan_note_r]) begin
          trk_we = 1'b1;
          if (!held_r[scan_note_r]) begin
            emit = 1'b1;
            emit_vel = vel_prod[16:10];
            emit_offset = win_rd_r.first_start;
          end
        end else if (held_r[scan_note_r] && elapsed >= TB'(hold_r)) begin
          emit = 1'b1;
          emit_off = 1'b1;
          emit_offset = (excess >= TB'(capture_r)) ? 16'd0
                                                   : capture_r - excess[15:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      seen_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (state_r == negt_pkg::ST_EVWR && ev_ok_r) begin
        seen_r[pitch_r] <= 1'b1;
      end
      if (scan_active && emit) begin
        held_r[scan_note_r] <= !emit_off;
      end
      if (state_r == negt_pkg::ST_DONE && bank_r) begin
        seen_r <= '0;
      end
      if (scan_active && emit) begin
        pend_r <= 1'b1;
        out_valid_r <= pend_r;
      end else if (state_r == negt_pkg::ST_DONE) begin
        pend_r <= 1'b0;
        out_valid_r <= pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_active && emit) begin
      pend_off_r <= emit_off;
      pend_note_r <= scan_note_r;
      pend_vel_r <= emit_vel;
      pend_off_val_r <= emit_offset;
      out_is_off_r <= pend_off_r;
      out_note_r <= pend_note_r;
      out_vel_r <= pend_vel_r;
      out_offset_r <= pend_off_val_r;
      out_last_r <= 1'b0;
    end else if (state_r == negt_pkg::ST_DONE) begin
      out_is_off_r <= pend_off_r;
      out_note_r <= pend_note_r;
      out_vel_r <= pend_vel_r;
      out_offset_r <= pend_off_val_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_is_off = out_is_off_r;
  assign out_note = out_note_r;
  assign out_velocity = out_vel_r;
  assign out_offset = out_offset_r;
  assign out_last = out_last_r;

  `NEGT_ASSERT_IMPL(a_no_out_idle, clk, rst_n, state_r == negt_pkg::ST_IDLE,
    !out_valid || out_last, "result outside close")
  `NEGT_ASSERT_IMPL(a_off_zero_vel, clk, rst_n, out_valid && out_is_off,
    out_velocity == 7'd0, "note-off with velocity")
  `NEGT_ASSERT_NEXT(a_done_flush, clk, rst_n, state_r == negt_pkg::ST_DONE,
    !pend_r, "pending result kept after close")
endmodule

// ===== tb/tb_note_event_gate_tracker_top.sv =====
`timescale 1ns / 100ps
module tb_note_event_gate_tracker_top;

  typedef struct {
    logic        is_off;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] offset;
    logic        last;
  } note_msg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [6:0]  in_pitch = '0;
  logic [15:0] in_start_sample = '0;
  logic [15:0] in_end_sample = '0;
  logic [10:0] in_amplitude = '0;
  logic        in_bank = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_is_off;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [15:0] out_offset;
  logic        out_last;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLOSE = 1'b1;
  localparam int CYCLE_LIMIT = 2000000;

  note_event_gate_tracker_top i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] silence_len, capture_len, min_hold;
  logic [10:0] min_level;
  logic        held[negt_pkg::NOTES];
  logic        seen[negt_pkg::NOTES];
  logic [15:0] first_start[negt_pkg::NOTES];
  logic [15:0] last_end[negt_pkg::NOTES];
  logic [10:0] peak_amp[negt_pkg::NOTES];
  logic [31:0] last_seen_abs[negt_pkg::NOTES];
  logic [31:0] window_base;

  note_msg_t pending_msgs[$];
  int errors = 0;
  int cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    note_msg_t m;
    if (rst_n && out_valid) begin
      if (pending_msgs.size() == 0) begin
        report("unexpected message note", 32'(out_note), 32'd0);
      end else begin
        m = pending_msgs.pop_front();
        if (out_is_off !== m.is_off) report("is_off", 32'(out_is_off), 32'(m.is_off));
        if (out_note !== m.note) report("note", 32'(out_note), 32'(m.note));
        if (out_velocity !== m.velocity)
          report("velocity", 32'(out_velocity), 32'(m.velocity));
        if (out_offset !== m.offset) report("offset", 32'(out_offset), 32'(m.offset));
        if (out_last !== m.last) report("last", 32'(out_last), 32'(m.last));
      end
    end
  end

  function automatic void clear_window();
    for (int i = 0; i < negt_pkg::NOTES; i++) begin
      seen[i] = 1'b0;
      first_start[i] = capture_len;
      last_end[i] = '0;
      peak_amp[i] = '0;
    end
  endfunction

  function automatic void track_event(logic [6:0] p, logic [15:0] s, logic [15:0] e,
                                      logic [10:0] a);
    logic [15:0] adj_s, adj_e;
    if (s < silence_len || e <= silence_len) return;
    adj_s = s - silence_len;
    adj_e = e - silence_len;
    if (adj_e > capture_len) adj_e = capture_len;
    seen[p] = 1'b1;
    if (adj_s < first_start[p]) first_start[p] = adj_s;
    if (adj_e > last_end[p]) last_end[p] = adj_e;
    if (a > peak_amp[p]) peak_amp[p] = a;
  endfunction

  function automatic void scan_bank(logic b);
    int count;
    int n;
    logic [31:0] win_end, elapsed, excess;
    logic [10:0] amp, lv, v;
    logic [17:0] prod;
    note_msg_t m;
    count = 0;
    win_end = window_base + capture_len;
    for (int j = 0; j < negt_pkg::SCAN; j++) begin
      n = b * negt_pkg::SCAN + j;
      if (seen[n]) begin
        if (!held[n]) begin
          amp = peak_amp[n] > negt_pkg::FULL_SCALE ? negt_pkg::FULL_SCALE : peak_amp[n];
          lv = min_level > negt_pkg::FULL_SCALE ? negt_pkg::FULL_SCALE : min_level;
          v = amp > lv ? amp : lv;
          prod = v * 18'd127;
          m = '{1'b0, 7'(n), 7'(prod >> 10), first_start[n], 1'b0};
          pending_msgs.push_back(m);
          count++;
          held[n] = 1'b1;
        end
        last_seen_abs[n] = window_base + last_end[n];
      end else if (held[n]) begin
        elapsed = win_end - last_seen_abs[n];
        if (elapsed >= min_hold) begin
          excess = elapsed - min_hold;
          m = '{1'b1, 7'(n), 7'd0,
                excess >= capture_len ? 16'd0 : capture_len - 16'(excess), 1'b0};
          pending_msgs.push_back(m);
          count++;
          held[n] = 1'b0;
        end
      end
    end
    if (count > 0) pending_msgs[pending_msgs.size() - 1].last = 1'b1;
    if (b) begin
      clear_window();
      window_base = window_base + capture_len;
    end
  endfunction

  task automatic send_item(logic c, logic [6:0] p, logic [15:0] s, logic [15:0] e,
                           logic [10:0] a, logic b);
    int n;
    start <= 1'b1;
    in_cmd <= c;
    in_pitch <= p;
    in_start_sample <= s;
    in_end_sample <= e;
    in_amplitude <= a;
    in_bank <= b;
    do @(posedge clk); while (busy);
    if (c == CMD_EVENT) track_event(p, s, e, a);
    else scan_bank(b);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy || pending_msgs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      negt_pkg::REG_SILENCE: silence_len = val;
      negt_pkg::REG_CAPTURE: capture_len = val;
      negt_pkg::REG_HOLD:    min_hold = val;
      default:               min_level = val[10:0];
    endcase
  endtask

  task automatic set_config(logic [15:0] sl, logic [15:0] cl, logic [15:0] mh,
                            logic [10:0] ml);
    drain();
    write_reg(negt_pkg::REG_SILENCE, sl);
    write_reg(negt_pkg::REG_CAPTURE, cl);
    write_reg(negt_pkg::REG_HOLD, mh);
    write_reg(negt_pkg::REG_LEVEL, 16'(ml));
    cfg_we <= 1'b0;
  endtask

  task automatic close_window();
    send_item(CMD_CLOSE, 7'($urandom), 16'($urandom), 16'($urandom), 11'($urandom), 1'b0);
    send_item(CMD_CLOSE, 7'($urandom), 16'($urandom), 16'($urandom), 11'($urandom), 1'b1);
  endtask

  task automatic test_directed();
    set_config(16'd100, 16'd1000, 16'd0, 11'd0);
    send_item(CMD_CLOSE, 7'd0, 16'd0, 16'd0, 11'd0, 1'b0);
    send_item(CMD_EVENT, 7'd0, 16'd100, 16'd101, 11'd0, 1'b1);
    send_item(CMD_EVENT, 7'd127, 16'd65535, 16'd65535, 11'd2047, 1'b0);
    send_item(CMD_EVENT, 7'd5, 16'd99, 16'd500, 11'd512, 1'b0);
    send_item(CMD_EVENT, 7'd6, 16'd200, 16'd100, 11'd512, 1'b0);
    send_item(CMD_EVENT, 7'd7, 16'd300, 16'd400, 11'd1024, 1'b0);
    send_item(CMD_EVENT, 7'd7, 16'd250, 16'd350, 11'd1500, 1'b0);
    send_item(CMD_EVENT, 7'd64, 16'd5000, 16'd6000, 11'd1, 1'b0);
    close_window();
    send_item(CMD_EVENT, 7'd7, 16'd150, 16'd160, 11'd300, 1'b0);
    close_window();
    close_window();
    set_config(16'd0, 16'd65535, 16'd65535, 11'd2047);
    send_item(CMD_EVENT, 7'd3, 16'd0, 16'd65535, 11'd10, 1'b0);
    close_window();
    close_window();
    close_window();
    set_config(16'd65534, 16'd1, 16'd0, 11'd1024);
    send_item(CMD_EVENT, 7'd9, 16'd65534, 16'd65535, 11'd0, 1'b0);
    close_window();
    close_window();
  endtask

  task automatic test_random(int items);
    int k;
    k = 0;
    while (k < items) begin
      if ($urandom_range(0, 5) == 0) begin
        close_window();
        k += 2;
      end else begin
        send_item($urandom_range(0, 15) == 0 ? CMD_CLOSE : CMD_EVENT, 7'($urandom),
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000)),
                  16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000)),
                  11'($urandom), 1'($urandom));
        k++;
      end
    end
  endtask

  task automatic test_settings();
    set_config(16'($urandom_range(0, 500)), 16'($urandom_range(500, 3000)),
               16'($urandom_range(0, 4000)), 11'($urandom));
    test_random(30);
    set_config(16'd0, 16'($urandom_range(1, 65535)), 16'($urandom), 11'($urandom_range(0, 1024)));
    test_random(26);
    set_config(16'($urandom), 16'($urandom_range(1, 2000)), 16'd0, 11'd0);
    test_random(26);
  endtask

  initial begin
    silence_len = '0;
    capture_len = 16'd44100;
    min_hold = '0;
    min_level = '0;
    window_base = '0;
    for (int i = 0; i < negt_pkg::NOTES; i++) begin
      held[i] = 1'b0;
      last_seen_abs[i] = '0;
    end
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
